/* src/ffac_pkg.sv */
// shared constants and helpers for the first-fit allocator
package ffac_pkg;

    localparam int HeapUnits    = 1024;
    localparam int GranuleBytes = 8;
    localparam int MaxBlocks    = 32;
    localparam int ExtSlots     = MaxBlocks + 1;

    localparam int UW  = 10;
    localparam int LW  = 11;
    localparam int SZW = 14;
    localparam int HW  = 8;
    localparam int BIW = 5;
    localparam int EIW = 6;
    localparam int CW  = 6;
    localparam int GW  = $clog2(GranuleBytes);

    localparam logic [2:0] ST_ALLOC     = 3'd0;
    localparam logic [2:0] ST_ALLOC_CMP = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_FREED     = 3'd3;
    localparam logic [2:0] ST_NOTFOUND  = 3'd4;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam int BW = HW + UW + SZW;
    localparam int XW = UW + LW;

    // saturates so that an oversized request never fits
    function automatic logic [LW-1:0] units_of(input logic [SZW-1:0] b);
        logic [SZW:0] t;
        logic [SZW:0] q;
        t = {1'b0, b} + (SZW+1)'(GranuleBytes - 1);
        q = t >> GW;
        return (q > (SZW+1)'((1 << LW) - 1)) ? '1 : LW'(q);
    endfunction

    function automatic logic [2:0] frag_of(input logic [SZW-1:0] b);
        logic [GW-1:0] r;
        r = GW'(0) - b[GW-1:0];
        return 3'(r);
    endfunction

endpackage

/* src/ffac_ram.sv */
// generic single-port write, single-port read ram with registered read
module ffac_ram #(
    parameter int Width = 8,
    parameter int Depth = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

/* src/first_fit_allocator_compaction.sv */
// top level of the first-fit allocator with coalescing and compaction
//
// input channel s_*: op (allocate or free), handle, size_bytes.
// result channel m_*: status, start_unit, units, frag_bytes, one per request.
// block table and free-extent list live in two rams, walked entry by entry
// through a read-modify-write sequencer that issues a read and then uses the
// registered read data before moving on to the next entry.
// an allocate walks the extents and then the blocks, with a compaction adding
// a repack pass over the blocks; a free walks the blocks and then the extents.
// one request is in flight at a time; s_ready is high only when idle.
// a finished result moves to an output register and sits there until taken;
// the next request is accepted and processed meanwhile, and its result waits
// in the sequencer until the output register is free.
// reset (synchronous, active low) sets one free extent covering the heap
// and an empty block table, and needs no clearing pass.
module first_fit_allocator_compaction (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [7:0]  s_handle,
    input  logic [13:0] s_size_bytes,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [9:0]  m_start_unit,
    output logic [10:0] m_units,
    output logic [2:0]  m_frag_bytes
);
    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001,
        S_AFIND = 16'h0002,
        S_PACK  = 16'h0004,
        S_ATRY  = 16'h0008,
        S_AEXT  = 16'h0010,
        S_EDROP = 16'h0020,
        S_BFIND = 16'h0040,
        S_BINS  = 16'h0080,
        S_FFIND = 16'h0100,
        S_FDEL  = 16'h0200,
        S_XFIND = 16'h0400,
        S_XMERG = 16'h0800,
        S_XINS  = 16'h1000,
        S_DONE  = 16'h2000,
        S_WAIT  = 16'h4000,
        S_PACKW = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    // block ram
    logic                       b_we;
    logic [ffac_pkg::BIW-1:0]   b_waddr, b_raddr;
    logic [ffac_pkg::BW-1:0]    b_wdata, b_rdata;
    // extent ram
    logic                       x_we;
    logic [ffac_pkg::EIW-1:0]   x_waddr, x_raddr;
    logic [ffac_pkg::XW-1:0]    x_wdata, x_rdata;

    ffac_ram #(.Width(ffac_pkg::BW), .Depth(ffac_pkg::MaxBlocks)) u_bram (
        .aclk(aclk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
        .raddr(b_raddr), .rdata(b_rdata));
    ffac_ram #(.Width(ffac_pkg::XW), .Depth(ffac_pkg::ExtSlots)) u_xram (
        .aclk(aclk), .we(x_we), .waddr(x_waddr), .wdata(x_wdata),
        .raddr(x_raddr), .rdata(x_rdata));

    // extent 0 shadow reset value until first write
    logic x0_valid_reg, x0_valid_next;

    logic [ffac_pkg::CW-1:0]  bcnt_reg, bcnt_next, xcnt_reg, xcnt_next;
    logic                     op_reg, op_next;
    logic [ffac_pkg::HW-1:0]  hnd_reg, hnd_next;
    logic [ffac_pkg::SZW-1:0] sz_reg, sz_next;
    logic [ffac_pkg::LW-1:0]  u_reg, u_next;
    logic [ffac_pkg::CW-1:0]  i_reg, i_next;
    logic [ffac_pkg::CW-1:0]  k_reg, k_next;
    logic                     rd_reg, rd_next;   // read data valid, i or k
    logic [ffac_pkg::BW-1:0]  carry_reg, carry_next;
    logic [ffac_pkg::XW-1:0]  xprev_reg, xprev_next;
    logic [ffac_pkg::UW:0]    pos_reg, pos_next;
    logic                     cmp_reg, cmp_next;
    logic [ffac_pkg::UW-1:0]  s_reg, s_next;
    logic [2:0]  ost_reg, ost_next;
    logic [9:0]  ostart_reg, ostart_next;
    logic [10:0] ounits_reg, ounits_next;
    logic [2:0]  ofrag_reg, ofrag_next;
    logic        mv_reg, mv_next;
    // output register
    logic [2:0]  mst_reg, mst_next;
    logic [9:0]  mstart_reg, mstart_next;
    logic [10:0] munits_reg, munits_next;
    logic [2:0]  mfrag_reg, mfrag_next;

    logic [ffac_pkg::XW-1:0] xr;
    logic [ffac_pkg::UW-1:0] xr_s, bs;
    logic [ffac_pkg::LW-1:0] xr_l, bu;
    logic [ffac_pkg::HW-1:0] bh;
    logic [ffac_pkg::SZW-1:0] bb;

    always_comb begin
        xr   = (i_reg == '0 && !x0_valid_reg) ?
               {ffac_pkg::UW'(0), ffac_pkg::LW'(ffac_pkg::HeapUnits)} : x_rdata;
        xr_s = xr[ffac_pkg::XW-1 -: ffac_pkg::UW];
        xr_l = xr[ffac_pkg::LW-1:0];
        bh   = b_rdata[ffac_pkg::BW-1 -: ffac_pkg::HW];
        bs   = b_rdata[ffac_pkg::SZW +: ffac_pkg::UW];
        bb   = b_rdata[ffac_pkg::SZW-1:0];
        bu   = ffac_pkg::units_of(bb);
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = mv_reg;
    assign m_status     = mst_reg;
    assign m_start_unit = mstart_reg;
    assign m_units      = munits_reg;
    assign m_frag_bytes = mfrag_reg;

    always_comb begin
        state_next = state_reg;
        x0_valid_next = x0_valid_reg;
        bcnt_next = bcnt_reg; xcnt_next = xcnt_reg;
        op_next = op_reg; hnd_next = hnd_reg; sz_next = sz_reg; u_next = u_reg;
        i_next = i_reg; k_next = k_reg; rd_next = 1'b0;
        carry_next = carry_reg; xprev_next = xprev_reg; pos_next = pos_reg;
        cmp_next = cmp_reg; s_next = s_reg;
        ost_next = ost_reg; ostart_next = ostart_reg; ounits_next = ounits_reg;
        ofrag_next = ofrag_reg;
        mv_next = mv_reg && !m_ready;
        mst_next = mst_reg; mstart_next = mstart_reg; munits_next = munits_reg;
        mfrag_next = mfrag_reg;
        b_we = 1'b0; b_waddr = i_reg[ffac_pkg::BIW-1:0]; b_wdata = carry_reg;
        b_raddr = i_reg[ffac_pkg::BIW-1:0];
        x_we = 1'b0; x_waddr = i_reg; x_wdata = xprev_reg; x_raddr = i_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    op_next = s_op; hnd_next = s_handle; sz_next = s_size_bytes;
                    u_next = ffac_pkg::units_of(s_size_bytes);
                    i_next = '0; cmp_next = 1'b0;
                    b_raddr = '0; x_raddr = '0;
                    if (s_op == ffac_pkg::OP_FREE) begin
                        state_next = S_FFIND;
                    end else if (s_size_bytes == '0 ||
                                 bcnt_reg >= ffac_pkg::CW'(ffac_pkg::MaxBlocks)) begin
                        ost_next = ffac_pkg::ST_FULL; state_next = S_DONE;
                    end else begin
                        state_next = S_AFIND;
                    end
                end
            end
            // scan extents for first fit
            S_AFIND: begin
                if (!rd_reg) begin
                    x_raddr = i_reg; rd_next = 1'b1;
                end else if (i_reg >= xcnt_reg) begin
                    if (cmp_reg) begin
                        ost_next = ffac_pkg::ST_FULL; state_next = S_DONE;
                    end else begin
                        i_next = '0; pos_next = '0; state_next = S_PACK;
                    end
                end else if (xr_l >= u_reg) begin
                    xprev_next = xr; state_next = S_AEXT;
                end else begin
                    i_next = i_reg + 1'b1;
                end
            end
            // repack blocks from unit 0
            S_PACK: begin
                if (i_reg >= bcnt_reg) begin
                    if (pos_reg < (ffac_pkg::UW+1)'(ffac_pkg::HeapUnits)) begin
                        x_we = 1'b1; x_waddr = '0;
                        x_wdata = {pos_reg[ffac_pkg::UW-1:0],
                                   ffac_pkg::LW'(ffac_pkg::HeapUnits) -
                                   ffac_pkg::LW'(pos_reg)};
                        x0_valid_next = 1'b1;
                        xcnt_next = ffac_pkg::CW'(1);
                    end else begin
                        xcnt_next = '0;
                    end
                    cmp_next = 1'b1; i_next = '0; state_next = S_ATRY;
                end else begin
                    b_raddr = i_reg[ffac_pkg::BIW-1:0]; state_next = S_PACKW;
                end
            end
            S_PACKW: begin
                b_we = 1'b1; b_waddr = i_reg[ffac_pkg::BIW-1:0];
                b_wdata = {bh, pos_reg[ffac_pkg::UW-1:0], bb};
                pos_next = pos_reg + (ffac_pkg::UW+1)'(bu);
                i_next = i_reg + 1'b1; state_next = S_PACK;
            end
            S_ATRY: begin
                x_raddr = '0; rd_next = 1'b1; state_next = S_AFIND;
            end
            // trim or drop the chosen extent
            S_AEXT: begin
                s_next = xprev_reg[ffac_pkg::XW-1 -: ffac_pkg::UW];
                if (xprev_reg[ffac_pkg::LW-1:0] > u_reg) begin
                    x_we = 1'b1; x_waddr = i_reg;
                    x_wdata = {xprev_reg[ffac_pkg::XW-1 -: ffac_pkg::UW] +
                               ffac_pkg::UW'(u_reg),
                               xprev_reg[ffac_pkg::LW-1:0] - u_reg};
                    if (i_reg == '0) x0_valid_next = 1'b1;
                    k_next = '0; state_next = S_BFIND;
                end else begin
                    i_next = i_reg + 1'b1; state_next = S_EDROP;
                end
            end
            // shift extents down over the dropped one
            S_EDROP: begin
                if (i_reg >= xcnt_reg) begin
                    xcnt_next = xcnt_reg - 1'b1; k_next = '0;
                    state_next = (op_reg == ffac_pkg::OP_FREE) ? S_DONE : S_BFIND;
                end else if (!rd_reg) begin
                    x_raddr = i_reg; rd_next = 1'b1;
                end else begin
                    x_we = 1'b1; x_waddr = i_reg - 1'b1; x_wdata = xr;
                    if (i_reg == ffac_pkg::CW'(1)) x0_valid_next = 1'b1;
                    i_next = i_reg + 1'b1;
                end
            end
            // find insertion point then shift blocks up
            S_BFIND: begin
                if (k_reg >= bcnt_reg) begin
                    i_next = k_reg;
                    carry_next = {hnd_reg, s_reg, sz_reg};
                    state_next = S_BINS;
                end else if (!rd_reg) begin
                    b_raddr = k_reg[ffac_pkg::BIW-1:0]; rd_next = 1'b1;
                end else if (bs > s_reg) begin
                    i_next = k_reg;
                    carry_next = {hnd_reg, s_reg, sz_reg};
                    state_next = S_BINS;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_BINS: begin
                if (i_reg >= bcnt_reg) begin
                    b_we = 1'b1; b_waddr = i_reg[ffac_pkg::BIW-1:0];
                    b_wdata = carry_reg;
                    bcnt_next = bcnt_reg + 1'b1;
                    ost_next = cmp_reg ? ffac_pkg::ST_ALLOC_CMP : ffac_pkg::ST_ALLOC;
                    ostart_next = s_reg; ounits_next = u_reg;
                    ofrag_next = ffac_pkg::frag_of(sz_reg);
                    state_next = S_DONE;
                end else if (!rd_reg) begin
                    b_raddr = i_reg[ffac_pkg::BIW-1:0]; rd_next = 1'b1;
                end else begin
                    b_we = 1'b1; b_waddr = i_reg[ffac_pkg::BIW-1:0];
                    b_wdata = carry_reg; carry_next = b_rdata;
                    i_next = i_reg + 1'b1;
                end
            end
            // free: find handle
            S_FFIND: begin
                if (i_reg >= bcnt_reg) begin
                    ost_next = ffac_pkg::ST_NOTFOUND; state_next = S_DONE;
                end else if (!rd_reg) begin
                    b_raddr = i_reg[ffac_pkg::BIW-1:0]; rd_next = 1'b1;
                end else if (bh == hnd_reg) begin
                    s_next = bs; u_next = bu;
                    i_next = i_reg + 1'b1; state_next = S_FDEL;
                end else begin
                    i_next = i_reg + 1'b1;
                end
            end
            S_FDEL: begin
                if (i_reg >= bcnt_reg) begin
                    bcnt_next = bcnt_reg - 1'b1;
                    i_next = '0; xprev_next = '0; k_next = '0;
                    state_next = S_XFIND;
                end else if (!rd_reg) begin
                    b_raddr = i_reg[ffac_pkg::BIW-1:0]; rd_next = 1'b1;
                end else begin
                    b_we = 1'b1; b_waddr = 5'(i_reg - 1'b1); b_wdata = b_rdata;
                    i_next = i_reg + 1'b1;
                end
            end
            // find first extent starting above s; xprev holds extent k-1
            S_XFIND: begin
                if (i_reg >= xcnt_reg) begin
                    k_next = i_reg; state_next = S_XMERG;
                end else if (!rd_reg) begin
                    x_raddr = i_reg; rd_next = 1'b1;
                end else if (xr_s > s_reg) begin
                    k_next = i_reg; carry_next = ffac_pkg::BW'(xr);
                    state_next = S_XMERG;
                end else begin
                    xprev_next = xr; i_next = i_reg + 1'b1;
                end
            end
            S_XMERG: begin
                begin
                    logic pm, nm;
                    logic [ffac_pkg::UW:0] pend, send;
                    logic [ffac_pkg::UW-1:0] ns;
                    logic [ffac_pkg::LW-1:0] nl;
                    pend = (ffac_pkg::UW+1)'(xprev_reg[ffac_pkg::XW-1 -: ffac_pkg::UW]) +
                           (ffac_pkg::UW+1)'(xprev_reg[ffac_pkg::LW-1:0]);
                    send = (ffac_pkg::UW+1)'(s_reg) + (ffac_pkg::UW+1)'(u_reg);
                    ns = carry_reg[ffac_pkg::XW-1 -: ffac_pkg::UW];
                    nl = carry_reg[ffac_pkg::LW-1:0];
                    pm = (k_reg != '0) && (pend == (ffac_pkg::UW+1)'(s_reg));
                    nm = (k_reg < xcnt_reg) && ((ffac_pkg::UW+1)'(ns) == send);
                    ost_next = ffac_pkg::ST_FREED; ostart_next = s_reg;
                    ounits_next = u_reg; ofrag_next = '0;
                    if (pm) begin
                        x_we = 1'b1; x_waddr = k_reg - 1'b1;
                        x_wdata = {xprev_reg[ffac_pkg::XW-1 -: ffac_pkg::UW],
                                   xprev_reg[ffac_pkg::LW-1:0] + u_reg +
                                   (nm ? nl : ffac_pkg::LW'(0))};
                        if (k_reg == ffac_pkg::CW'(1)) x0_valid_next = 1'b1;
                        if (nm) begin
                            i_next = k_reg + 1'b1; state_next = S_EDROP;
                        end else begin
                            state_next = S_DONE;
                        end
                    end else if (nm) begin
                        x_we = 1'b1; x_waddr = k_reg;
                        x_wdata = {s_reg, nl + u_reg};
                        if (k_reg == '0) x0_valid_next = 1'b1;
                        state_next = S_DONE;
                    end else if (xcnt_reg < ffac_pkg::CW'(ffac_pkg::ExtSlots)) begin
                        i_next = k_reg; xprev_next = {s_reg, u_reg};
                        state_next = S_XINS;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            // shift extents up from k, carrying the new one in
            S_XINS: begin
                if (i_reg >= xcnt_reg) begin
                    x_we = 1'b1; x_waddr = i_reg; x_wdata = xprev_reg;
                    if (i_reg == '0) x0_valid_next = 1'b1;
                    xcnt_next = xcnt_reg + 1'b1; state_next = S_DONE;
                end else if (!rd_reg) begin
                    x_raddr = i_reg; rd_next = 1'b1;
                end else begin
                    x_we = 1'b1; x_waddr = i_reg; x_wdata = xprev_reg;
                    if (i_reg == '0) x0_valid_next = 1'b1;
                    xprev_next = xr; i_next = i_reg + 1'b1;
                end
            end
            S_DONE: begin
                if (ost_next == ffac_pkg::ST_FULL || ost_reg == ffac_pkg::ST_FULL ||
                    ost_reg == ffac_pkg::ST_NOTFOUND) begin
                    ostart_next = '0; ounits_next = '0; ofrag_next = '0;
                end
                state_next = S_WAIT;
            end
            // hand the result to the output register once it is free
            S_WAIT: begin
                if (!mv_reg || m_ready) begin
                    mv_next = 1'b1;
                    mst_next = ost_reg; mstart_next = ostart_reg;
                    munits_next = ounits_reg; mfrag_next = ofrag_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            x0_valid_reg <= 1'b0;
            bcnt_reg <= '0;
            xcnt_reg <= ffac_pkg::CW'(1);
            rd_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            x0_valid_reg <= x0_valid_next;
            bcnt_reg <= bcnt_next;
            xcnt_reg <= xcnt_next;
            rd_reg <= rd_next;
            mv_reg <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg <= op_next; hnd_reg <= hnd_next; sz_reg <= sz_next; u_reg <= u_next;
        i_reg <= i_next; k_reg <= k_next; carry_reg <= carry_next;
        xprev_reg <= xprev_next; pos_reg <= pos_next; cmp_reg <= cmp_next;
        s_reg <= s_next; ost_reg <= ost_next; ostart_reg <= ostart_next;
        ounits_reg <= ounits_next; ofrag_reg <= ofrag_next;
        mst_reg <= mst_next; mstart_reg <= mstart_next;
        munits_reg <= munits_next; mfrag_reg <= mfrag_next;
    end
endmodule

/* tb/first_fit_allocator_compaction_tb.sv */
// testbench for the first-fit allocator: directed and random requests checked against a predictor
module first_fit_allocator_compaction_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  start_unit;
        logic [10:0] units;
        logic [2:0]  frag_bytes;
    } heap_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_op = ffac_pkg::OP_ALLOC;
    logic [7:0]  s_handle = '0;
    logic [13:0] s_size_bytes = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [9:0]  m_start_unit;
    logic [10:0] m_units;
    logic [2:0]  m_frag_bytes;

    // predictor copy of heap state
    int unsigned live_handle[ffac_pkg::MaxBlocks];
    int unsigned live_start[ffac_pkg::MaxBlocks];
    int unsigned live_bytes[ffac_pkg::MaxBlocks];
    int unsigned live_count;
    int unsigned hole_start[ffac_pkg::ExtSlots];
    int unsigned hole_len[ffac_pkg::ExtSlots];
    int unsigned hole_count;

    heap_result_t pending_results[$];
    int  error_count = 0;
    int  cycle_count = 0;
    bit  quiet_mode = 0;
    bit  recv_hold = 0;
    int  hold_cycles = 0;

    first_fit_allocator_compaction u_dut (.*);

    always #1 aclk = ~aclk;

    function automatic int unsigned granules(int unsigned b);
        return (b + ffac_pkg::GranuleBytes - 1) / ffac_pkg::GranuleBytes;
    endfunction

    function automatic void drop_hole(int unsigned k);
        for (int unsigned i = k; i + 1 < hole_count; i++) begin
            hole_start[i] = hole_start[i+1];
            hole_len[i]   = hole_len[i+1];
        end
        if (hole_count > 0) hole_count--;
    endfunction

    function automatic void pack_live();
        int unsigned pos;
        pos = 0;
        for (int unsigned i = 0; i < live_count; i++) begin
            live_start[i] = pos;
            pos += granules(live_bytes[i]);
        end
        if (pos < ffac_pkg::HeapUnits) begin
            hole_start[0] = pos;
            hole_len[0]   = ffac_pkg::HeapUnits - pos;
            hole_count    = 1;
        end else begin
            hole_count = 0;
        end
    endfunction

    function automatic heap_result_t predict_alloc(int unsigned h, int unsigned sz);
        heap_result_t r;
        int unsigned u, i, k, st;
        bit hit;
        r = '0;
        r.status = ffac_pkg::ST_FULL;
        if (sz == 0 || live_count >= ffac_pkg::MaxBlocks) return r;
        u = granules(sz);
        hit = 0;
        st = ffac_pkg::ST_ALLOC;
        for (i = 0; i < hole_count; i++) begin
            if (hole_len[i] >= u) begin
                hit = 1;
                break;
            end
        end
        if (!hit) begin
            pack_live();
            st = ffac_pkg::ST_ALLOC_CMP;
            i = 0;
            hit = hole_count > 0 && hole_len[0] >= u;
        end
        if (!hit) return r;
        r.start_unit = 10'(hole_start[i]);
        if (hole_len[i] > u) begin
            hole_start[i] += u;
            hole_len[i]   -= u;
        end else begin
            drop_hole(i);
        end
        for (k = 0; k < live_count; k++)
            if (live_start[k] > r.start_unit) break;
        for (int unsigned j = live_count; j > k; j--) begin
            live_handle[j] = live_handle[j-1];
            live_start[j]  = live_start[j-1];
            live_bytes[j]  = live_bytes[j-1];
        end
        live_handle[k] = h;
        live_start[k]  = r.start_unit;
        live_bytes[k]  = sz;
        live_count++;
        r.status     = 3'(st);
        r.units      = 11'(u);
        r.frag_bytes = 3'((ffac_pkg::GranuleBytes - sz % ffac_pkg::GranuleBytes) %
                          ffac_pkg::GranuleBytes);
        return r;
    endfunction

    function automatic heap_result_t predict_free(int unsigned h);
        heap_result_t r;
        int unsigned j, k, s, u;
        r = '0;
        r.status = ffac_pkg::ST_NOTFOUND;
        for (j = 0; j < live_count; j++)
            if (live_handle[j] == h) break;
        if (j >= live_count) return r;
        s = live_start[j];
        u = granules(live_bytes[j]);
        for (int unsigned i = j; i + 1 < live_count; i++) begin
            live_handle[i] = live_handle[i+1];
            live_start[i]  = live_start[i+1];
            live_bytes[i]  = live_bytes[i+1];
        end
        live_count--;
        for (k = 0; k < hole_count; k++)
            if (hole_start[k] > s) break;
        if (k > 0 && hole_start[k-1] + hole_len[k-1] == s) begin
            hole_len[k-1] += u;
            if (k < hole_count && hole_start[k] == s + u) begin
                hole_len[k-1] += hole_len[k];
                drop_hole(k);
            end
        end else if (k < hole_count && hole_start[k] == s + u) begin
            hole_start[k] = s;
            hole_len[k]  += u;
        end else if (hole_count < ffac_pkg::ExtSlots) begin
            for (int unsigned i = hole_count; i > k; i--) begin
                hole_start[i] = hole_start[i-1];
                hole_len[i]   = hole_len[i-1];
            end
            hole_start[k] = s;
            hole_len[k]   = u;
            hole_count++;
        end
        r.status     = ffac_pkg::ST_FREED;
        r.start_unit = 10'(s);
        r.units      = 11'(u);
        return r;
    endfunction

    task automatic send_request(logic op, int unsigned h, int unsigned sz);
        heap_result_t r;
        if (!quiet_mode && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        s_valid      <= 1'b1;
        s_op         <= op;
        s_handle     <= 8'(h);
        s_size_bytes <= 14'(sz);
        do @(posedge aclk); while (!s_ready);
        r = (op == ffac_pkg::OP_ALLOC) ? predict_alloc(h, sz) : predict_free(h);
        pending_results.push_back(r);
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // ready side idling
    always @(posedge aclk) begin
        if (recv_hold) begin
            m_ready <= 1'b0;
        end else if (quiet_mode) begin
            m_ready <= 1'b1;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            hold_cycles <= $urandom_range(1, 11) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge aclk) begin
        heap_result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected transaction status=%0d", m_status);
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_status !== exp_r.status) begin
                    $error("status expected %0d actual %0d", exp_r.status, m_status);
                    error_count++;
                end
                if (m_start_unit !== exp_r.start_unit) begin
                    $error("start_unit expected %0d actual %0d", exp_r.start_unit,
                           m_start_unit);
                    error_count++;
                end
                if (m_units !== exp_r.units) begin
                    $error("units expected %0d actual %0d", exp_r.units, m_units);
                    error_count++;
                end
                if (m_frag_bytes !== exp_r.frag_bytes) begin
                    $error("frag_bytes expected %0d actual %0d", exp_r.frag_bytes,
                           m_frag_bytes);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic test_directed();
        send_request(ffac_pkg::OP_ALLOC, 8'h00, 1);
        send_request(ffac_pkg::OP_ALLOC, 8'hFF, 8);
        send_request(ffac_pkg::OP_ALLOC, 8'hAA, 0);
        send_request(ffac_pkg::OP_ALLOC, 8'h55, 8192);
        send_request(ffac_pkg::OP_ALLOC, 8'h01, 16383);
        send_request(ffac_pkg::OP_FREE, 8'h00, 14'h3FFF);
        send_request(ffac_pkg::OP_FREE, 8'h77, 0);
        send_request(ffac_pkg::OP_ALLOC, 8'hFF, 7);
        send_request(ffac_pkg::OP_FREE, 8'hFF, 0);
        send_request(ffac_pkg::OP_FREE, 8'hFF, 0);
        send_request(ffac_pkg::OP_FREE, 8'h55, 0);
        send_request(ffac_pkg::OP_FREE, 8'h55, 0);
        wait_drained();
    endtask

    // fragment the heap, then force compaction, a failed retry and a solid pack
    task automatic test_compaction();
        for (int i = 0; i < 8; i++) send_request(ffac_pkg::OP_ALLOC, 8'(16 + i), 1024);
        for (int i = 0; i < 8; i += 2) send_request(ffac_pkg::OP_FREE, 8'(16 + i), 0);
        send_request(ffac_pkg::OP_ALLOC, 8'h30, 2048);
        send_request(ffac_pkg::OP_ALLOC, 8'h31, 4096);
        send_request(ffac_pkg::OP_ALLOC, 8'h32, 2048);
        send_request(ffac_pkg::OP_ALLOC, 8'h33, 8);
        for (int i = 0; i < 8; i++) send_request(ffac_pkg::OP_FREE, 8'(16 + i), 0);
        for (int i = 0; i < 4; i++) send_request(ffac_pkg::OP_FREE, 8'(48 + i), 0);
        wait_drained();
    endtask

    task automatic test_table_full();
        for (int i = 0; i < ffac_pkg::MaxBlocks + 1; i++)
            send_request(ffac_pkg::OP_ALLOC, 8'(i % 5), 8);
        for (int i = 0; i < ffac_pkg::MaxBlocks + 1; i++)
            send_request(ffac_pkg::OP_FREE, 8'(i % 5), 0);
        wait_drained();
    endtask

    task automatic test_backpressure();
        recv_hold = 1;
        fork
            for (int i = 0; i < 6; i++) send_request(ffac_pkg::OP_ALLOC, 8'(200 + i), 64);
            begin
                repeat (3000) @(posedge aclk);
                recv_hold = 0;
            end
        join
        for (int i = 0; i < 6; i++) send_request(ffac_pkg::OP_FREE, 8'(200 + i), 0);
        wait_drained();
    endtask

    task automatic test_random(int n);
        int unsigned h, sz;
        for (int i = 0; i < n; i++) begin
            if (i == n - n / 8) quiet_mode = 1;
            h = $urandom_range(0, 15);
            if ($urandom_range(0, 19) == 0) h = $urandom_range(0, 255);
            case ($urandom_range(0, 9))
                0:       sz = $urandom_range(0, 16383);
                1:       sz = $urandom_range(1024, 8192);
                default: sz = $urandom_range(1, 400);
            endcase
            send_request(1'($urandom_range(0, 9) < 5), h, sz);
        end
        wait_drained();
    endtask

    initial begin
        live_count    = 0;
        hole_start[0] = 0;
        hole_len[0]   = ffac_pkg::HeapUnits;
        hole_count    = 1;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_compaction();
        test_table_full();
        test_backpressure();
        test_random(1650);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

/* files.f */
src/ffac_pkg.sv
src/ffac_ram.sv
src/first_fit_allocator_compaction.sv
tb/first_fit_allocator_compaction_tb.sv
